// ===== rtl/egbr_pkg.sv =====
// ---------------------------------------------------------------------------
// Exp-Golomb bit reader package
// Shared operation codes, default sizes and the request/result types.
// ---------------------------------------------------------------------------
`default_nettype none

package egbr_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_BUFFER_BYTES   = 8192;
    localparam int DEF_MAX_FIELD_BITS = 32;

    // Field widths fixed by the request and result formats.
    localparam int OP_W    = 3;
    localparam int COUNT_W = 6;
    localparam int VALUE_W = 33;
    localparam int ACC_W   = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_U = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_S = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd4;
    localparam logic [OP_W-1:0] OP_UE     = 3'd5;
    localparam logic [OP_W-1:0] OP_SE     = 3'd6;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd7;

    // One input request.
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [7:0]         data_byte;
        logic [COUNT_W-1:0] bit_count;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        bits_used;
        logic                      error;
    } t_out_item;

    // Command handed to the sequencer, with the bit count already clamped.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COUNT_W-1:0] count;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/exp_golomb_bit_reader.sv =====
// Clear and append give no result. A query's result passes through the done
// state and then the output register. A read steps through its bits, with an
// address step and a RAM read step for every loaded buffer byte it touches.
// Throughput: one request at a time; the next is taken once the result sits
// in the output register. Reset clears position, fill count and output valid;
// the byte store is not cleared.
// ---------------------------------------------------------------------------
// Exp-Golomb bit reader
// Byte buffer with a bit position; fixed-width reads, peeks, ue/se decode, queries.
// ---------------------------------------------------------------------------
`default_nettype none

module exp_golomb_bit_reader
    import egbr_pkg::*;
#(
    parameter int BUFFER_BYTES   = DEF_BUFFER_BYTES,
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    localparam int LW    = $clog2(BUFFER_BYTES + 1);
    localparam int TOT_W = LW + 3;
    localparam int AW    = $clog2(BUFFER_BYTES);

    logic              r_out_valid, n_out_valid;
    t_out_item         r_out;
    logic [LW-1:0]     r_loaded, n_loaded;
    logic              r_found, n_found;
    logic [TOT_W-1:0]  r_last_one, n_last_one;

    logic              accept;
    logic              do_clear;
    logic              do_append;
    logic              start;
    t_cmd              cmd;
    logic [2:0]        lo_idx;
    logic              busy;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    logic              res_valid;
    logic              res_take;
    t_out_item         res;

    // Request decode.
    always_comb begin
        accept    = i_in_valid && !busy;
        do_clear  = accept && (i_in_data.operation == OP_CLEAR);
        do_append = accept && (i_in_data.operation == OP_APPEND)
                    && (r_loaded < LW'(BUFFER_BYTES));
        start     = accept && (i_in_data.operation != OP_CLEAR)
                    && (i_in_data.operation != OP_APPEND);
        cmd.op    = i_in_data.operation;
        cmd.count = (i_in_data.bit_count > COUNT_W'(MAX_FIELD_BITS))
                    ? COUNT_W'(MAX_FIELD_BITS) : i_in_data.bit_count;
    end

    // Lowest set bit of the appended byte, which is its last one in stream order.
    always_comb begin
        lo_idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (i_in_data.data_byte[i]) begin
                lo_idx = 3'(i);
            end
        end
    end

    // Fill count and last-one tracker.
    always_comb begin
        n_loaded   = r_loaded;
        n_found    = r_found;
        n_last_one = r_last_one;
        if (do_clear) begin
            n_loaded = '0;
            n_found  = 1'b0;
        end else if (do_append) begin
            n_loaded = r_loaded + LW'(1);
            if (i_in_data.data_byte != 8'h00) begin
                n_found    = 1'b1;
                n_last_one = {r_loaded, 3'd7 - lo_idx};
            end
        end
    end

    // Output register between the sequencer and the result channel.
    always_comb begin
        res_take    = res_valid && (!r_out_valid || !i_out_stall);
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_loaded    <= '0;
            r_found     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_loaded    <= n_loaded;
            r_found     <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_one <= n_last_one;
        if (res_take) begin
            r_out <= res;
        end
    end

    egbr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_append),
        .i_waddr (r_loaded[AW-1:0]),
        .i_wdata (i_in_data.data_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    egbr_seq #(
        .BUFFER_BYTES   (BUFFER_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (cmd),
        .i_clear     (do_clear),
        .i_total     ({r_loaded, 3'b000}),
        .i_found     (r_found),
        .i_last_one  (r_last_one),
        .o_busy      (busy),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/egbr_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module egbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/egbr_format.sv =====
// ---------------------------------------------------------------------------
// Exp-Golomb bit reader result formatter
// Turns the accumulated bits into the signed result value for each command.
// ---------------------------------------------------------------------------
`default_nettype none

module egbr_format
    import egbr_pkg::*;
(
    input  wire logic [OP_W-1:0]         i_op,
    input  wire logic [COUNT_W-1:0]      i_count,
    input  wire logic [ACC_W-1:0]        i_acc,
    input  wire logic                    i_long,
    output logic signed [VALUE_W-1:0]    o_value
);

    logic [VALUE_W-1:0] low_mask;
    logic [VALUE_W-1:0] top_bit;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic               negative;

    // Masks for sign extension of an n-bit field.
    always_comb begin
        raw      = {1'b0, i_acc};
        low_mask = (VALUE_W'(1) << i_count) - VALUE_W'(1);
        top_bit  = low_mask ^ (low_mask >> 1);
        negative = |(raw & top_bit);
        mag      = {2'b00, i_acc[ACC_W-1:1]};
    end

    // The accumulator holds the code number plus one for ue and se.
    always_comb begin
        case (i_op)
            OP_READ_U, OP_PEEK: begin
                o_value = raw;
            end
            OP_READ_S: begin
                o_value = negative ? (raw | ~low_mask) : raw;
            end
            OP_UE: begin
                o_value = i_long ? '0 : raw - VALUE_W'(1);
            end
            OP_SE: begin
                // An even code number plus one is odd, which gives a negative value.
                if (i_long) begin
                    o_value = '0;
                end else begin
                    o_value = i_acc[0] ? -mag : mag;
                end
            end
            OP_QUERY: begin
                o_value = {{(VALUE_W-1){1'b0}}, i_acc[0]};
            end
            default: begin
                o_value = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/egbr_seq.sv =====
// ---------------------------------------------------------------------------
// Exp-Golomb bit reader sequencer
// Steps one bit per cycle through a shared shift unit, except while it fetches a buffer byte.
// ---------------------------------------------------------------------------
`default_nettype none

module egbr_seq
    import egbr_pkg::*;
#(
    parameter int BUFFER_BYTES   = DEF_BUFFER_BYTES,
    parameter int MAX_FIELD_BITS = DEF_MAX_FIELD_BITS,
    localparam int TOT_W = $clog2(BUFFER_BYTES + 1) + 3,
    localparam int AW    = $clog2(BUFFER_BYTES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_clear,
    input  wire logic [TOT_W-1:0] i_total,
    input  wire logic             i_found,
    input  wire logic [TOT_W-1:0] i_last_one,
    output logic                  o_busy,
    output logic [AW-1:0]         o_rd_addr,
    input  wire logic [7:0]       i_rd_data,
    output logic                  o_res_valid,
    input  wire logic             i_res_take,
    output t_out_item             o_res
);

    localparam int CUR_W = TOT_W + 1;
    localparam logic [CUR_W-1:0] POS_LIMIT = CUR_W'(8 * BUFFER_BYTES);
    localparam logic [COUNT_W-1:0] MAX_BITS = COUNT_W'(MAX_FIELD_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BIT  = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [TOT_W-1:0]   r_pos, n_pos;
    logic [CUR_W-1:0]   r_cur, n_cur;
    logic [7:0]         r_byte, n_byte;
    logic               r_byte_ok, n_byte_ok;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_zeros, n_zeros;
    logic [COUNT_W-1:0] r_n, n_n;
    logic [OP_W-1:0]    r_op, n_op;
    logic               r_suffix, n_suffix;
    logic               r_long, n_long;
    logic               r_err, n_err;

    logic               in_range;
    logic               bit_val;
    logic               is_fixed;
    logic               is_code;
    logic               q_err;
    logic               q_val;
    logic [COUNT_W-1:0] used;
    logic signed [VALUE_W-1:0] value;

    // Bit at the cursor: loaded data from the byte register, zero past the end.
    always_comb begin
        in_range = r_cur < {1'b0, i_total};
        bit_val  = in_range & r_byte[~r_cur[2:0]];
        is_fixed = (r_op == OP_READ_U) || (r_op == OP_READ_S) || (r_op == OP_PEEK);
        is_code  = (r_op == OP_UE) || (r_op == OP_SE);
        q_err    = (r_pos >= i_total) || !i_found;
        q_val    = !q_err && (r_pos < i_last_one);
    end

    // Sequencer and shared shift unit.
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_byte    = r_byte;
        n_byte_ok = r_byte_ok;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_zeros   = r_zeros;
        n_n       = r_n;
        n_op      = r_op;
        n_suffix  = r_suffix;
        n_long    = r_long;
        n_err     = r_err;

        case (r_state)
            S_IDLE: begin
                if (i_clear) begin
                    n_pos = '0;
                end else if (i_start) begin
                    n_op      = i_cmd.op;
                    n_n       = i_cmd.count;
                    n_cnt     = i_cmd.count;
                    n_cur     = {1'b0, r_pos};
                    n_byte_ok = 1'b0;
                    n_acc     = '0;
                    n_zeros   = '0;
                    n_suffix  = 1'b0;
                    n_long    = 1'b0;
                    n_err     = 1'b0;
                    if (i_cmd.op == OP_QUERY) begin
                        n_err   = q_err;
                        n_acc   = ACC_W'(q_val);
                        n_state = S_DONE;
                    end else if (i_cmd.op == OP_UE || i_cmd.op == OP_SE) begin
                        n_state = S_BIT;
                    end else if (i_cmd.count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_BIT;
                    end
                end
            end
            S_BIT: begin
                if (in_range && !r_byte_ok) begin
                    // The read address is presented this cycle.
                    n_state = S_LOAD;
                end else begin
                    n_cur = r_cur + CUR_W'(1);
                    if (!in_range) begin
                        n_err = 1'b1;
                    end
                    if (r_cur[2:0] == 3'd7) begin
                        n_byte_ok = 1'b0;
                    end
                    if (is_fixed || r_suffix) begin
                        n_acc = {r_acc[ACC_W-2:0], bit_val};
                        n_cnt = r_cnt - COUNT_W'(1);
                        if (r_cnt == COUNT_W'(1)) begin
                            n_state = S_DONE;
                        end
                    end else if (!bit_val) begin
                        // Leading zero of the prefix.
                        n_zeros = r_zeros + COUNT_W'(1);
                        if (n_zeros == MAX_BITS) begin
                            n_long  = 1'b1;
                            n_state = S_DONE;
                        end
                    end else begin
                        // The one that ends the prefix leads the code number plus one.
                        n_acc    = ACC_W'(1);
                        n_suffix = 1'b1;
                        n_cnt    = r_zeros;
                        if (r_zeros == '0) begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_LOAD: begin
                n_byte    = i_rd_data;
                n_byte_ok = 1'b1;
                n_state   = S_BIT;
            end
            S_DONE: begin
                if (i_res_take) begin
                    if (is_fixed && r_op != OP_PEEK || is_code) begin
                        n_pos = (r_cur > POS_LIMIT) ? POS_LIMIT[TOT_W-1:0] : r_cur[TOT_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_byte    <= n_byte;
        r_byte_ok <= n_byte_ok;
        r_acc     <= n_acc;
        r_cnt     <= n_cnt;
        r_zeros   <= n_zeros;
        r_n       <= n_n;
        r_op      <= n_op;
        r_suffix  <= n_suffix;
        r_long    <= n_long;
        r_err     <= n_err;
    end

    // Bits taken from the position by the finished command.
    always_comb begin
        case (r_op)
            OP_READ_U, OP_READ_S: begin
                used = r_n;
            end
            OP_UE, OP_SE: begin
                used = r_long ? MAX_BITS : {r_zeros[COUNT_W-2:0], 1'b1};
            end
            default: begin
                used = '0;
            end
        endcase
    end

    egbr_format u_format (
        .i_op    (r_op),
        .i_count (r_n),
        .i_acc   (r_acc),
        .i_long  (r_long),
        .o_value (value)
    );

    assign o_busy          = (r_state != S_IDLE);
    assign o_rd_addr       = r_cur[AW+2:3];
    assign o_res_valid     = (r_state == S_DONE);
    assign o_res.value     = value;
    assign o_res.bits_used = used;
    assign o_res.error     = r_err || r_long;

endmodule

`default_nettype wire

// ===== rtl/egbr_checker.sv =====
// ---------------------------------------------------------------------------
// Exp-Golomb bit reader checker
// Port-level properties of the reader, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module egbr_checker
    import egbr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      i_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      i_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item i_out_data
);

    // A stalled result stays and holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
    else $error("stalled result changed");

    // A read request keeps the block busy in the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && i_in_data.operation != OP_CLEAR
        && i_in_data.operation != OP_APPEND |=> i_in_stall)
    else $error("read request not held busy");

    // Clear and append never produce a result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && !i_out_valid
        && (i_in_data.operation == OP_CLEAR || i_in_data.operation == OP_APPEND)
        |=> !i_out_valid)
    else $error("result appeared after clear or append");

    // A new result only comes out of a busy block.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_stall))
    else $error("result without a request in progress");

endmodule

bind exp_golomb_bit_reader egbr_checker u_egbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

`default_nettype wire
